>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check shorthands shared by the RTL. Define ASSERT_OFF to drop
// every check.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/rlmsc_pkg.sv
// ---------------------------------------------------------------------------
// rlmsc_pkg
// Shared types and constants of the LED matrix scan controller: word
// layouts, operation and result codes, and the microcode control word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlmsc_pkg;

	// pixel storage: red 23..16, green 15..8, blue 7..0
	localparam int PIX_W = 24;
	localparam int BAL_W = 6;
	localparam int CFG_W = 6;

	// operation codes
	localparam logic [2:0] OP_WRITE    = 3'd0;
	localparam logic [2:0] OP_FILL     = 3'd1;
	localparam logic [2:0] OP_SWAP     = 3'd2;
	localparam logic [2:0] OP_REFRESH  = 3'd3;
	localparam logic [2:0] OP_BALANCE  = 3'd4;
	localparam logic [2:0] OP_READ_WR  = 3'd5;
	localparam logic [2:0] OP_READ_ACT = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_GRAY    = 2'd1;
	localparam logic [1:0] KIND_BALANCE = 2'd2;

	// row driver code for all rows closed
	localparam logic [3:0] ROWS_CLOSED = 4'd8;

	// configuration register indices
	localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] CFG_BAL_RED      = 2'd1;
	localparam logic [1:0] CFG_BAL_GREEN    = 2'd2;
	localparam logic [1:0] CFG_BAL_BLUE     = 2'd3;

	typedef struct packed {
		logic [2:0]        op;
		logic signed [7:0] pos_x;
		logic signed [7:0] pos_y;
		logic [23:0]       pixel_color;
		logic              copy_after_swap;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] shift_word;
		logic [23:0] read_color;
		logic [3:0]  row_enable;
		logic        last;
	} out_word_t;

	// microcode fields
	typedef enum logic [1:0] {RD_NONE, RD_ACTIVE, RD_WRITE} rd_sel_t;
	typedef enum logic [1:0] {ADDR_XY, ADDR_CNT, ADDR_ROW} addr_sel_t;
	typedef enum logic [1:0] {SINK_NONE, SINK_READ, SINK_GRAY, SINK_COPY} sink_t;
	typedef enum logic [1:0] {WR_NONE, WR_XY, WR_CNT, WR_CLEAR} wr_sel_t;
	typedef enum logic [1:0] {LIM_PIXELS, LIM_COLS, LIM_ROWS} lim_t;
	typedef enum logic [1:0] {COND_ALWAYS, COND_NOT_LAST, COND_COPY} cond_t;

	// datapath part of one control word
	typedef struct packed {
		rd_sel_t   rd;
		addr_sel_t addr;
		sink_t     sink;
		wr_sel_t   wr;
		logic      swap;
		logic      emit_bal;
		logic      cnt_inc;
		lim_t      lim;
	} ctrl_t;

	// datapath flags that steer jumps
	typedef struct packed {
		logic cnt_last;
		logic copy;
	} seq_flags_t;

endpackage

>>> rtl/core/rgb_led_matrix_scan_controller.sv
// ---------------------------------------------------------------------------
// rgb_led_matrix_scan_controller
// Double-buffered RGB LED matrix controller: pixel writes, fills, buffer
// swaps with optional copy, pixel reads, white-balance and row refresh
// shift words, run by a microcoded sequencer over two frame RAMs.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_ready   in_word  (rlmsc_pkg::in_word_t)
//   out      output     out_valid / out_ready out_word (rlmsc_pkg::out_word_t)
//   cfg      input      cfg_wr_en             cfg_index, cfg_wdata
//
// Each bank has one write and one read port; one pixel a cycle while
// the output is not stalled. After reset a clearing pass zeroes both
// banks; in_ready stays low meanwhile. A stalled output freezes the step
// counter and the RAM read stage until the waiting word is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_led_matrix_scan_controller #(
	parameter int MATRIX_COLS = 8,
	parameter int MATRIX_ROWS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rlmsc_pkg::in_word_t               in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rlmsc_pkg::out_word_t              out_word,
	input  logic                              cfg_wr_en,
	input  logic [1:0]                        cfg_index,
	input  logic [rlmsc_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int NPIX = MATRIX_COLS * MATRIX_ROWS;
	localparam int AW   = $clog2(NPIX);
	localparam int RW   = $clog2(MATRIX_ROWS);
	localparam int PW   = rlmsc_pkg::PIX_W;
	localparam int BW   = rlmsc_pkg::BAL_W;

	// RGB565 expands with low bits zero
	function automatic logic [PW-1:0] unpack_color(input logic fmt, input logic [23:0] c);
		return fmt ? c : {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
	endfunction

	function automatic logic [23:0] pack_color(input logic fmt, input logic [PW-1:0] p);
		return fmt ? p : {8'h00, p[23:19], p[15:10], p[7:3]};
	endfunction

	// configuration
	logic          pixel_format_q;
	logic [BW-1:0] bal_red_q;
	logic [BW-1:0] bal_green_q;
	logic [BW-1:0] bal_blue_q;

	// control state
	logic          active_is_b_q;
	logic [RW-1:0] scan_row_q;
	logic [AW-1:0] cnt_q;
	logic          out_valid_q;

	// item registers
	logic signed [7:0] pos_x_q;
	logic signed [7:0] pos_y_q;
	logic [PW-1:0]     color_q;
	logic              copy_q;

	// read stage
	rlmsc_pkg::sink_t sink_s1;
	logic [AW-1:0]    addr_s1;
	logic             last_s1;
	logic             on_grid_s1;
	logic             bank_b_s1;

	rlmsc_pkg::out_word_t out_word_q;
	rlmsc_pkg::out_word_t emit_word;
	rlmsc_pkg::ctrl_t     ctrl;
	rlmsc_pkg::seq_flags_t flags;

	logic          idle;
	logic          in_fire;
	logic          on_grid;
	logic [13:0]   xy_lin;
	logic [AW-1:0] xy_addr;
	logic [RW-1:0] row_idx;
	logic [AW-1:0] row_addr;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] lim;
	logic          cnt_last;
	logic          emit_s1;
	logic          emit;
	logic          out_free;
	logic          stall;
	logic          go;
	logic          rd_bank_b;
	logic          re;
	logic          wr_any;
	logic          wr_both;
	logic [AW-1:0] wr_addr;
	logic [PW-1:0] wr_data;
	logic          we_a;
	logic          we_b;
	logic [PW-1:0] rdata_a;
	logic [PW-1:0] rdata_b;
	logic [PW-1:0] rd_pix;

	// sequencer
	assign flags.cnt_last = cnt_last;
	assign flags.copy     = copy_q;

	rlmsc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.op     (in_word.op),
		.stall  (stall),
		.flags  (flags),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	assign in_ready = idle;
	assign in_fire  = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= 1'b0;
			bal_red_q      <= '1;
			bal_green_q    <= '1;
			bal_blue_q     <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rlmsc_pkg::CFG_PIXEL_FORMAT: pixel_format_q <= cfg_wdata[0];
				rlmsc_pkg::CFG_BAL_RED:      bal_red_q      <= cfg_wdata[BW-1:0];
				rlmsc_pkg::CFG_BAL_GREEN:    bal_green_q    <= cfg_wdata[BW-1:0];
				rlmsc_pkg::CFG_BAL_BLUE:     bal_blue_q     <= cfg_wdata[BW-1:0];
				default: begin
				end
			endcase
		end
	end

	// item capture, colour stored unpacked
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_x_q <= in_word.pos_x;
			pos_y_q <= in_word.pos_y;
			color_q <= unpack_color(pixel_format_q, in_word.pixel_color);
			copy_q  <= in_word.copy_after_swap;
		end
	end

	// addressing
	assign on_grid = !pos_x_q[7] && !pos_y_q[7]
		&& (pos_x_q[6:0] < 7'(MATRIX_COLS)) && (pos_y_q[6:0] < 7'(MATRIX_ROWS));
	assign xy_lin   = 14'(pos_y_q[6:0]) * 14'(MATRIX_COLS) + 14'(pos_x_q[6:0]);
	assign xy_addr  = xy_lin[AW-1:0];
	assign row_idx  = RW'(MATRIX_ROWS - 1) - scan_row_q;
	assign row_addr = AW'(row_idx) * AW'(MATRIX_COLS) + cnt_q;

	always_comb begin
		case (ctrl.addr)
			rlmsc_pkg::ADDR_CNT: rd_addr = cnt_q;
			rlmsc_pkg::ADDR_ROW: rd_addr = row_addr;
			default:             rd_addr = xy_addr;
		endcase
	end

	// loop bound
	always_comb begin
		case (ctrl.lim)
			rlmsc_pkg::LIM_COLS: lim = AW'(MATRIX_COLS - 1);
			rlmsc_pkg::LIM_ROWS: lim = AW'(MATRIX_ROWS - 1);
			default:             lim = AW'(NPIX - 1);
		endcase
	end
	assign cnt_last = (cnt_q == lim);

	// output stall freezes the whole sequencer
	assign emit_s1  = (sink_s1 == rlmsc_pkg::SINK_READ) || (sink_s1 == rlmsc_pkg::SINK_GRAY);
	assign emit     = emit_s1 || ctrl.emit_bal;
	assign out_free = !out_valid_q || out_ready;
	assign stall    = emit && !out_free;
	assign go       = !stall;

	// RAM read request
	assign re        = go && (ctrl.rd != rlmsc_pkg::RD_NONE);
	assign rd_bank_b = (ctrl.rd == rlmsc_pkg::RD_WRITE) ? !active_is_b_q : active_is_b_q;
	assign rd_pix    = bank_b_s1 ? rdata_b : rdata_a;

	// RAM write request: microcode writes or copy write-back from the read stage
	always_comb begin
		wr_any  = 1'b0;
		wr_both = 1'b0;
		wr_addr = cnt_q;
		wr_data = color_q;
		case (ctrl.wr)
			rlmsc_pkg::WR_XY: begin
				wr_any  = on_grid;
				wr_addr = xy_addr;
			end
			rlmsc_pkg::WR_CNT: begin
				wr_any = 1'b1;
			end
			rlmsc_pkg::WR_CLEAR: begin
				wr_both = 1'b1;
				wr_data = '0;
			end
			default: begin
				if (sink_s1 == rlmsc_pkg::SINK_COPY) begin
					wr_any  = 1'b1;
					wr_addr = addr_s1;
					wr_data = rd_pix;
				end
			end
		endcase
	end

	// bank a is the write bank while b is active
	assign we_a = go && (wr_both || (wr_any && active_is_b_q));
	assign we_b = go && (wr_both || (wr_any && !active_is_b_q));

	rlmsc_ram #(.WIDTH(PW), .DEPTH(NPIX)) u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (re),
		.raddr (rd_addr),
		.rdata (rdata_a)
	);

	rlmsc_ram #(.WIDTH(PW), .DEPTH(NPIX)) u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (re),
		.raddr (rd_addr),
		.rdata (rdata_b)
	);

	// read stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_s1 <= rlmsc_pkg::SINK_NONE;
		end else if (go) begin
			sink_s1 <= ctrl.sink;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			addr_s1    <= rd_addr;
			last_s1    <= cnt_last;
			on_grid_s1 <= on_grid;
			bank_b_s1  <= rd_bank_b;
		end
	end

	// counter, bank select, scan row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			active_is_b_q <= 1'b0;
			scan_row_q    <= '0;
		end else if (go) begin
			if (ctrl.cnt_inc) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (ctrl.swap) begin
				active_is_b_q <= !active_is_b_q;
			end
			// advance as the latching word is loaded into the output register
			if ((sink_s1 == rlmsc_pkg::SINK_GRAY) && last_s1) begin
				scan_row_q <= (scan_row_q == RW'(MATRIX_ROWS - 1)) ? '0 : scan_row_q + 1'b1;
			end
		end
	end

	// result word
	always_comb begin
		emit_word            = '0;
		emit_word.row_enable = rlmsc_pkg::ROWS_CLOSED;
		case (sink_s1)
			rlmsc_pkg::SINK_READ: begin
				emit_word.kind       = rlmsc_pkg::KIND_PIXEL;
				emit_word.read_color = on_grid_s1 ? pack_color(pixel_format_q, rd_pix) : '0;
				emit_word.last       = 1'b1;
			end
			rlmsc_pkg::SINK_GRAY: begin
				emit_word.kind       = rlmsc_pkg::KIND_GRAY;
				emit_word.shift_word = {rd_pix[7:0], rd_pix[15:8], rd_pix[23:16]};
				emit_word.last       = last_s1;
				if (last_s1) begin
					emit_word.row_enable = 4'(scan_row_q);
				end
			end
			default: begin
				emit_word.kind       = rlmsc_pkg::KIND_BALANCE;
				emit_word.shift_word = {6'b000000, bal_blue_q, bal_green_q, bal_red_q};
				emit_word.last       = cnt_last;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (emit && out_free) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_word_q <= emit_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// checks
	`ASSERT_IMPLIES(a_ready_stage_empty, clk, arst_n, in_ready, sink_s1 == rlmsc_pkg::SINK_NONE)
	`ASSERT_IMPLIES(a_ready_cnt_zero, clk, arst_n, in_ready, cnt_q == '0)
	`ASSERT_IMPLIES(a_row_closed_midrun, clk, arst_n, out_valid && !out_word.last, out_word.row_enable == rlmsc_pkg::ROWS_CLOSED)
	`ASSERT_NEXT(a_stall_freezes, clk, arst_n, stall, $stable(cnt_q) && $stable(sink_s1))

endmodule

>>> rtl/core/rlmsc_ram.sv
// ---------------------------------------------------------------------------
// rlmsc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlmsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/rlmsc_seq.sv
// ---------------------------------------------------------------------------
// rlmsc_seq
// Microcode sequencer: step counter, control store and jump logic. One
// control word per step drives the frame datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlmsc_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [2:0]             op,
	input  logic                   stall,
	input  rlmsc_pkg::seq_flags_t  flags,
	output rlmsc_pkg::ctrl_t       ctrl,
	output logic                   idle
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_FILL,
		ST_SWAP,
		ST_COPY,
		ST_REFRESH,
		ST_BALANCE,
		ST_READ_WR,
		ST_READ_ACT,
		ST_DRAIN
	} step_t;

	typedef struct packed {
		rlmsc_pkg::ctrl_t dp;
		rlmsc_pkg::cond_t cond;
		step_t            jt;
		step_t            jf;
	} uword_t;

	// control store
	function automatic uword_t rom(input step_t s);
		uword_t w;
		w      = '0;
		w.cond = rlmsc_pkg::COND_ALWAYS;
		w.jt   = ST_IDLE;
		w.jf   = ST_IDLE;
		unique case (s)
			ST_CLEAR: begin
				w.dp.wr      = rlmsc_pkg::WR_CLEAR;
				w.dp.cnt_inc = 1'b1;
				w.dp.lim     = rlmsc_pkg::LIM_PIXELS;
				w.cond       = rlmsc_pkg::COND_NOT_LAST;
				w.jt         = ST_CLEAR;
			end
			ST_IDLE: begin
			end
			ST_WRITE: begin
				w.dp.wr = rlmsc_pkg::WR_XY;
			end
			ST_FILL: begin
				w.dp.wr      = rlmsc_pkg::WR_CNT;
				w.dp.cnt_inc = 1'b1;
				w.dp.lim     = rlmsc_pkg::LIM_PIXELS;
				w.cond       = rlmsc_pkg::COND_NOT_LAST;
				w.jt         = ST_FILL;
			end
			ST_SWAP: begin
				w.dp.swap = 1'b1;
				w.cond    = rlmsc_pkg::COND_COPY;
				w.jt      = ST_COPY;
			end
			ST_COPY: begin
				w.dp.rd      = rlmsc_pkg::RD_ACTIVE;
				w.dp.addr    = rlmsc_pkg::ADDR_CNT;
				w.dp.sink    = rlmsc_pkg::SINK_COPY;
				w.dp.cnt_inc = 1'b1;
				w.dp.lim     = rlmsc_pkg::LIM_PIXELS;
				w.cond       = rlmsc_pkg::COND_NOT_LAST;
				w.jt         = ST_COPY;
				w.jf         = ST_DRAIN;
			end
			ST_REFRESH: begin
				w.dp.rd      = rlmsc_pkg::RD_ACTIVE;
				w.dp.addr    = rlmsc_pkg::ADDR_ROW;
				w.dp.sink    = rlmsc_pkg::SINK_GRAY;
				w.dp.cnt_inc = 1'b1;
				w.dp.lim     = rlmsc_pkg::LIM_COLS;
				w.cond       = rlmsc_pkg::COND_NOT_LAST;
				w.jt         = ST_REFRESH;
				w.jf         = ST_DRAIN;
			end
			ST_BALANCE: begin
				w.dp.emit_bal = 1'b1;
				w.dp.cnt_inc  = 1'b1;
				w.dp.lim      = rlmsc_pkg::LIM_ROWS;
				w.cond        = rlmsc_pkg::COND_NOT_LAST;
				w.jt          = ST_BALANCE;
			end
			ST_READ_WR: begin
				w.dp.rd   = rlmsc_pkg::RD_WRITE;
				w.dp.addr = rlmsc_pkg::ADDR_XY;
				w.dp.sink = rlmsc_pkg::SINK_READ;
				w.jt      = ST_DRAIN;
			end
			ST_READ_ACT: begin
				w.dp.rd   = rlmsc_pkg::RD_ACTIVE;
				w.dp.addr = rlmsc_pkg::ADDR_XY;
				w.dp.sink = rlmsc_pkg::SINK_READ;
				w.jt      = ST_DRAIN;
			end
			ST_DRAIN: begin
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	// dispatch table: first step of each operation
	function automatic step_t entry(input logic [2:0] code);
		step_t s;
		unique case (code)
			rlmsc_pkg::OP_WRITE:    s = ST_WRITE;
			rlmsc_pkg::OP_FILL:     s = ST_FILL;
			rlmsc_pkg::OP_SWAP:     s = ST_SWAP;
			rlmsc_pkg::OP_REFRESH:  s = ST_REFRESH;
			rlmsc_pkg::OP_BALANCE:  s = ST_BALANCE;
			rlmsc_pkg::OP_READ_WR:  s = ST_READ_WR;
			rlmsc_pkg::OP_READ_ACT: s = ST_READ_ACT;
			default:                s = ST_IDLE;
		endcase
		return s;
	endfunction

	step_t  step_q;
	uword_t uw;

	assign uw   = rom(step_q);
	assign ctrl = uw.dp;
	assign idle = (step_q == ST_IDLE);

	// step counter; clearing pass runs first out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLEAR;
		end else if (!stall) begin
			if (step_q == ST_IDLE) begin
				if (start) begin
					step_q <= entry(op);
				end
			end else begin
				unique case (uw.cond)
					rlmsc_pkg::COND_ALWAYS:   step_q <= uw.jt;
					rlmsc_pkg::COND_NOT_LAST: step_q <= flags.cnt_last ? uw.jf : uw.jt;
					rlmsc_pkg::COND_COPY:     step_q <= flags.copy ? uw.jt : uw.jf;
					default:                  step_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule

>>> tb/sv/rgb_led_matrix_scan_controller_test.sv
// ---------------------------------------------------------------------------
// rgb_led_matrix_scan_controller_test
// Self-checking bench for the double-buffered LED matrix controller. A
// scoreboard keeps its own copy of both frame banks, the scan row and the
// registers, and queues the words each accepted command must produce. Every
// word taken from the output is compared field by field, in order. A short
// directed run covers the edge coordinates and every command. Random phases
// under several register settings follow, with random gaps on both sides, a
// long output stall and a pause that drains the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_led_matrix_scan_controller_test;

	localparam int COLS          = 8;
	localparam int ROWS          = 8;
	localparam int PIXELS        = COLS * ROWS;
	localparam int RESET_CYCLES  = 6;
	localparam int MAX_GAP       = 14;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = PIXELS + 16;  // covers a fill or a copying swap
	localparam int PHASE_ITEMS   = 46;
	localparam int PHASES        = 5;
	localparam int TIMEOUT_NS    = 1_000_000;

	// op code with no function in the block
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// -----------------------------------------------------------------------
	// Scoreboard: frame bank mirror and queue of expected output words
	// -----------------------------------------------------------------------
	class scan_scoreboard;
		logic [23:0]          frame [2][PIXELS];
		bit                   active_bank;
		int                   scan_row;
		bit                   fmt_888;
		logic [5:0]           bal_red, bal_green, bal_blue;
		rlmsc_pkg::out_word_t pending_words [$];
		int                   errors;

		function new();
			for (int i = 0; i < PIXELS; i++) begin
				frame[0][i] = '0;
				frame[1][i] = '0;
			end
			active_bank = 1'b0;
			scan_row    = 0;
			fmt_888     = 1'b0;
			bal_red     = 6'd63;
			bal_green   = 6'd63;
			bal_blue    = 6'd63;
			errors      = 0;
		endfunction

		function void set_registers(bit fmt, logic [5:0] red, logic [5:0] green,
				logic [5:0] blue);
			fmt_888   = fmt;
			bal_red   = red;
			bal_green = green;
			bal_blue  = blue;
		endfunction

		function bit on_matrix(rlmsc_pkg::in_word_t w);
			int x, y;
			x = $signed(w.pos_x);
			y = $signed(w.pos_y);
			return x >= 0 && x < COLS && y >= 0 && y < ROWS;
		endfunction

		// incoming colour to stored r,g,b; RGB565 drops the upper byte
		function logic [23:0] to_stored(logic [23:0] c);
			if (fmt_888)
				return c;
			return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
		endfunction

		// stored pixel back to the configured format
		function logic [23:0] to_format(logic [23:0] p);
			if (fmt_888)
				return p;
			return {8'h00, p[23:19], p[15:10], p[7:3]};
		endfunction

		function void queue_result(logic [1:0] kind, logic [23:0] shift,
				logic [23:0] colour, logic [3:0] row_en, bit fin);
			rlmsc_pkg::out_word_t r;
			r.kind       = kind;
			r.shift_word = shift;
			r.read_color = colour;
			r.row_enable = row_en;
			r.last       = fin;
			pending_words.push_back(r);
		endfunction

		// advance the mirror by one accepted command word
		function void note_word(rlmsc_pkg::in_word_t w);
			int          idx, row;
			bit          on_grid;
			logic [23:0] pix, colour;
			on_grid = on_matrix(w);
			idx = $signed(w.pos_y) * COLS + $signed(w.pos_x);
			case (w.op)
				rlmsc_pkg::OP_WRITE: begin
					if (on_grid)
						frame[!active_bank][idx] = to_stored(w.pixel_color);
				end
				rlmsc_pkg::OP_FILL: begin
					colour = to_stored(w.pixel_color);
					for (int i = 0; i < PIXELS; i++)
						frame[!active_bank][i] = colour;
				end
				rlmsc_pkg::OP_SWAP: begin
					active_bank = !active_bank;
					if (w.copy_after_swap)
						for (int i = 0; i < PIXELS; i++)
							frame[!active_bank][i] = frame[active_bank][i];
				end
				rlmsc_pkg::OP_REFRESH: begin
					// bottom row first as the counter climbs; last word opens the row
					row = ROWS - 1 - scan_row;
					for (int col = 0; col < COLS; col++) begin
						pix = frame[active_bank][row * COLS + col];
						queue_result(rlmsc_pkg::KIND_GRAY,
							{pix[7:0], pix[15:8], pix[23:16]}, '0,
							(col == COLS - 1) ? 4'(scan_row) : rlmsc_pkg::ROWS_CLOSED,
							col == COLS - 1);
					end
					scan_row = (scan_row == ROWS - 1) ? 0 : scan_row + 1;
				end
				rlmsc_pkg::OP_BALANCE: begin
					for (int i = 0; i < ROWS; i++)
						queue_result(rlmsc_pkg::KIND_BALANCE,
							{6'd0, bal_blue, bal_green, bal_red},
							'0, rlmsc_pkg::ROWS_CLOSED, i == ROWS - 1);
				end
				rlmsc_pkg::OP_READ_WR, rlmsc_pkg::OP_READ_ACT: begin
					colour = '0;
					if (on_grid)
						colour = to_format(frame[(w.op == rlmsc_pkg::OP_READ_ACT)
							? active_bank : !active_bank][idx]);
					queue_result(rlmsc_pkg::KIND_PIXEL, '0, colour,
						rlmsc_pkg::ROWS_CLOSED, 1'b1);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_field(string name, logic [23:0] got, logic [23:0] want);
			if (got !== want)
				report($sformatf("%s got %0h, want %0h", name, got, want));
		endtask

		task check_word(rlmsc_pkg::out_word_t got);
			rlmsc_pkg::out_word_t want;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word %0h", got));
				return;
			end
			want = pending_words.pop_front();
			check_field("kind", 24'(got.kind), 24'(want.kind));
			check_field("shift_word", got.shift_word, want.shift_word);
			check_field("read_color", got.read_color, want.read_color);
			check_field("row_enable", 24'(got.row_enable), 24'(want.row_enable));
			check_field("last", 24'(got.last), 24'(want.last));
		endtask
	endclass

	// -----------------------------------------------------------------------
	// Clock, reset and block
	// -----------------------------------------------------------------------
	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	rlmsc_pkg::in_word_t            in_word   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	rlmsc_pkg::out_word_t           out_word;
	logic                           cfg_wr_en = 1'b0;
	logic [1:0]                     cfg_index = rlmsc_pkg::CFG_PIXEL_FORMAT;
	logic [rlmsc_pkg::CFG_W-1:0]    cfg_wdata = '0;

	bit                  quiet        = 1'b0;  // no gaps on either side
	bit                  hold_request = 1'b0;  // one long output stall

	scan_scoreboard sb = new();

	always #1 clk = ~clk;

	rgb_led_matrix_scan_controller #(
		.MATRIX_COLS(COLS),
		.MATRIX_ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// -----------------------------------------------------------------------
	// Drivers
	// -----------------------------------------------------------------------
	function automatic rlmsc_pkg::in_word_t make_word(logic [2:0] op, int x, int y,
			logic [23:0] colour, bit copy);
		rlmsc_pkg::in_word_t w;
		w.op              = op;
		w.pos_x           = 8'(x);
		w.pos_y           = 8'(y);
		w.pixel_color     = colour;
		w.copy_after_swap = copy;
		return w;
	endfunction

	// offer one command word, optional gap first; valid stays up afterwards
	task automatic send_word(rlmsc_pkg::in_word_t w);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_word(w);
	endtask

	// stop offering until every expected word is out
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_words.size() != 0);
	endtask

	// block idle: drain, let trailing silent work finish, then write all four
	task automatic write_registers(bit fmt, logic [5:0] red, logic [5:0] green,
			logic [5:0] blue);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= rlmsc_pkg::CFG_PIXEL_FORMAT;
		cfg_wdata <= rlmsc_pkg::CFG_W'(fmt);
		@(posedge clk);
		cfg_index <= rlmsc_pkg::CFG_BAL_RED;
		cfg_wdata <= red;
		@(posedge clk);
		cfg_index <= rlmsc_pkg::CFG_BAL_GREEN;
		cfg_wdata <= green;
		@(posedge clk);
		cfg_index <= rlmsc_pkg::CFG_BAL_BLUE;
		cfg_wdata <= blue;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_registers(fmt, red, green, blue);
	endtask

	// mostly on-matrix coordinates, now and then anything the field holds
	function automatic rlmsc_pkg::in_word_t random_word();
		rlmsc_pkg::in_word_t w;
		int                  pick;
		w.pixel_color     = 24'($urandom());
		w.copy_after_swap = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) begin
			w.pos_x = 8'($urandom());
			w.pos_y = 8'($urandom());
		end else begin
			w.pos_x = 8'($urandom_range(0, COLS - 1));
			w.pos_y = 8'($urandom_range(0, ROWS - 1));
		end
		pick = $urandom_range(0, 99);
		if (pick < 32)      w.op = rlmsc_pkg::OP_WRITE;
		else if (pick < 48) w.op = rlmsc_pkg::OP_READ_WR;
		else if (pick < 64) w.op = rlmsc_pkg::OP_READ_ACT;
		else if (pick < 78) w.op = rlmsc_pkg::OP_REFRESH;
		else if (pick < 84) w.op = rlmsc_pkg::OP_BALANCE;
		else if (pick < 93) w.op = rlmsc_pkg::OP_SWAP;
		else if (pick < 97) w.op = rlmsc_pkg::OP_FILL;
		else                w.op = OP_UNUSED;
		return w;
	endfunction

	// edge coordinates, every command, reset contents of both banks
	task automatic run_directed();
		send_word(make_word(rlmsc_pkg::OP_READ_ACT, 0, 0, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_READ_WR, 7, 7, 24'hFFFFFF, 1'b1));
		send_word(make_word(rlmsc_pkg::OP_WRITE, 0, 0, 24'hFFFFFF, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_WRITE, 7, 7, 24'h00A5C3, 1'b0));
		// writes off the matrix are dropped
		send_word(make_word(rlmsc_pkg::OP_WRITE, -128, 0, 24'h123456, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_WRITE, 127, 127, 24'hFFFFFF, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_WRITE, 8, 3, 24'hFFFFFF, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_WRITE, 3, -1, 24'hFFFFFF, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_READ_WR, 0, 0, 24'h000000, 1'b0));
		// reads off the matrix give zero
		send_word(make_word(rlmsc_pkg::OP_READ_WR, -1, 0, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_READ_ACT, 127, -128, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_SWAP, 0, 0, 24'h000000, 1'b1));
		send_word(make_word(rlmsc_pkg::OP_REFRESH, 0, 0, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_READ_ACT, 7, 7, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_FILL, 0, 0, 24'h123456, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_READ_WR, 3, 4, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_SWAP, 0, 0, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_REFRESH, 0, 0, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_BALANCE, 0, 0, 24'h000000, 1'b0));
		send_word(make_word(OP_UNUSED, 0, 0, 24'hFFFFFF, 1'b1));
		// 888 format with balance at its low extreme
		write_registers(1'b1, 6'd0, 6'd0, 6'd0);
		send_word(make_word(rlmsc_pkg::OP_WRITE, 1, 1, 24'hABCDEF, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_READ_WR, 1, 1, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_BALANCE, 0, 0, 24'h000000, 1'b0));
		send_word(make_word(rlmsc_pkg::OP_REFRESH, 0, 0, 24'h000000, 1'b0));
	endtask

	// -----------------------------------------------------------------------
	// Output side: random stalls, one long hold on request
	// -----------------------------------------------------------------------
	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_request) begin
				hold_request = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_word(out_word);
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus and verdict
	// -----------------------------------------------------------------------
	initial begin : stimulus
		int                  counted;
		rlmsc_pkg::in_word_t w;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_registers(1'b0, 6'd63, 6'd0, 6'd42);
				1: write_registers(1'b1, 6'($urandom()), 6'($urandom()), 6'($urandom()));
				2: write_registers(1'b0, 6'($urandom()), 6'($urandom()), 6'($urandom()));
				3: write_registers(1'b1, 6'd63, 6'd63, 6'd63);
				default: write_registers(1'b0, 6'd0, 6'd63, 6'd0);
			endcase
			// one phase without gaps; another opens with the output held off
			quiet = (phase == 3);
			if (phase == 2)
				hold_request = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				w = random_word();
				send_word(w);
				if (w.op != OP_UNUSED
						&& !(w.op == rlmsc_pkg::OP_WRITE && !sb.on_matrix(w))) begin
					counted++;
					if (phase == 1 && counted == PHASE_ITEMS / 2)
						drain_results();
				end
			end
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
